// ===== src/fde_pkg.sv =====
`timescale 1ns / 1ps
package fde_pkg;

    localparam int ENTRY_BYTES = 32;
    localparam int STORE_BYTES = 256;
    localparam int MAX_SLOTS   = 20;
    localparam int SNAME_BYTES = 12;

    localparam logic [19:0] LIMIT_RESET = 20'd4096;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] MARK_FREE  = 8'hE5;
    localparam logic [7:0] ATTR_LFN   = 8'h0F;
    localparam logic [7:0] ATTR_VOL   = 8'h08;
    localparam logic [7:0] ORDER_LAST = 8'h40;
    localparam logic [5:0] SLOT_MASK  = 6'h3F;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        OP_END,
        OP_CLR,
        OP_LFN,
        OP_NAME
    } t_op;

    typedef struct packed {
        logic                        clr;
        t_op                         op;
        logic [ENTRY_BYTES*8-1:0]    ent;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } t_qctl;

    // byte offset of each long-name character inside the entry
    function automatic logic [4:0] lfn_off(input logic [3:0] k);
        logic [4:0] o;
        unique case (k)
            4'd0:    o = 5'd1;
            4'd1:    o = 5'd3;
            4'd2:    o = 5'd5;
            4'd3:    o = 5'd7;
            4'd4:    o = 5'd9;
            4'd5:    o = 5'd14;
            4'd6:    o = 5'd16;
            4'd7:    o = 5'd18;
            4'd8:    o = 5'd20;
            4'd9:    o = 5'd22;
            4'd10:   o = 5'd24;
            4'd11:   o = 5'd28;
            4'd12:   o = 5'd30;
            default: o = 5'd1;
        endcase
        return o;
    endfunction

endpackage

// ===== src/fde_front.sv =====
`timescale 1ns / 1ps
module fde_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_dir_byte,
    input  logic          i_new_listing,
    input  logic          i_q_full,
    output logic          o_push,
    output fde_pkg::t_cmd o_cmd
);

    logic [4:0] r_pos;
    logic [7:0] r_ent [fde_pkg::ENTRY_BYTES];
    logic       r_clr_pend;
    logic       w_acc;
    logic [4:0] w_pos;
    logic [fde_pkg::ENTRY_BYTES*8-1:0] w_flat;
    logic [7:0] w_first;
    logic [7:0] w_attr;

    assign o_in_ready = !((r_pos == 5'd31) && i_q_full);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_pos      = i_new_listing ? 5'd0 : r_pos;
    assign o_push     = w_acc && !i_new_listing && (r_pos == 5'd31);

    always_comb begin
        for (int i = 0; i < fde_pkg::ENTRY_BYTES - 1; i++) begin
            w_flat[i*8 +: 8] = r_ent[i];
        end
        w_flat[(fde_pkg::ENTRY_BYTES-1)*8 +: 8] = i_dir_byte;
    end

    assign w_first = w_flat[7:0];
    assign w_attr  = w_flat[11*8 +: 8];

    // classify the finished entry
    always_comb begin
        o_cmd.clr = r_clr_pend;
        o_cmd.ent = w_flat;
        if (w_first == 8'h00) begin
            o_cmd.op = fde_pkg::OP_END;
        end else if (w_first == fde_pkg::MARK_FREE) begin
            o_cmd.op = fde_pkg::OP_CLR;
        end else if (w_attr == fde_pkg::ATTR_LFN) begin
            o_cmd.op = fde_pkg::OP_LFN;
        end else if ((w_attr & fde_pkg::ATTR_VOL) != 8'h00) begin
            o_cmd.op = fde_pkg::OP_CLR;
        end else begin
            o_cmd.op = fde_pkg::OP_NAME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ent[w_pos] <= i_dir_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 5'd0;
            r_clr_pend <= 1'b0;
        end else if (w_acc) begin
            r_pos <= w_pos + 5'd1;
            if (i_new_listing) begin
                r_clr_pend <= 1'b1;
            end else if (o_push) begin
                r_clr_pend <= 1'b0;
            end
        end
    end

endmodule

// ===== src/fde_queue.sv =====
`timescale 1ns / 1ps
module fde_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fde_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output fde_pkg::t_cmd o_cmd,
    output fde_pkg::t_qctl o_ctl
);

    fde_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_cmd       = r_mem[r_rp];
    assign o_ctl.push  = i_push;
    assign o_ctl.pop   = i_pop;
    assign o_ctl.full  = (r_cnt == 2'd2);
    assign o_ctl.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== src/fde_back.sv =====
`timescale 1ns / 1ps
module fde_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_out_limit_we,
    input  logic [19:0]    i_out_limit,
    input  fde_pkg::t_cmd  i_cmd,
    input  fde_pkg::t_qctl i_qctl,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [63:0]    o_text_chunk,
    output logic [3:0]     o_chunk_bytes,
    output logic [1:0]     o_kind,
    output logic           o_last,
    output logic [19:0]    o_written_count
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_LFN  = 8'b00000010,
        S_SRD  = 8'b00000100,
        S_SCHK = 8'b00001000,
        S_DEC  = 8'b00010000,
        S_ERD  = 8'b00100000,
        S_EACC = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state      r_state;
    logic [19:0] r_limit;
    logic [19:0] r_off;
    logic        r_done;
    logic [fde_pkg::ENTRY_BYTES*8-1:0] r_ent;
    logic [8:0]  r_base;
    logic [3:0]  r_k;
    logic [7:0]  r_idx;
    logic [7:0]  r_c0;
    logic [7:0]  r_c1;
    logic [7:0]  r_len;
    logic        r_long;
    logic [7:0]  r_pos;
    logic [2:0]  r_cnt;
    logic [63:0] r_chunk;
    logic [7:0]  r_mem [fde_pkg::STORE_BYTES];
    logic [fde_pkg::STORE_BYTES-1:0] r_vld;
    logic [7:0]  r_rd;
    logic        r_rdv;

    logic [7:0]  w_rd_addr;
    logic [7:0]  w_rdval;
    logic        w_we;
    logic [8:0]  w_wa;
    logic [7:0]  w_wd;
    logic [4:0]  w_off;
    logic [15:0] w_ch;
    logic [5:0]  w_slot;
    logic [7:0]  c_sname [fde_pkg::SNAME_BYTES];
    logic [3:0]  c_slen;
    logic [7:0]  w_ln;
    logic [7:0]  w_a0;
    logic [7:0]  w_a1;
    logic        w_dot;
    logic        w_fit;
    logic [7:0]  w_char;
    logic [63:0] n_chunk;
    logic [3:0]  w_n;

    assign w_rdval   = r_rdv ? r_rd : 8'h00;
    assign w_rd_addr = (r_state == S_ERD) ? r_pos : r_idx;
    assign w_slot    = i_cmd.ent[5:0] & fde_pkg::SLOT_MASK;

    // 8.3 name: base up to space, dot and extension, cut at a zero byte
    always_comb begin
        logic stop;
        logic zf;
        logic [3:0] len;
        stop = 1'b0;
        zf   = 1'b0;
        len  = 4'd0;
        for (int i = 0; i < fde_pkg::SNAME_BYTES; i++) c_sname[i] = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (!stop && r_ent[k*8 +: 8] != fde_pkg::CH_SPACE) begin
                c_sname[len] = r_ent[k*8 +: 8];
                len = len + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        if (r_ent[8*8 +: 8] != fde_pkg::CH_SPACE) begin
            c_sname[len] = fde_pkg::CH_DOT;
            len  = len + 4'd1;
            stop = 1'b0;
            for (int k = 8; k < 11; k++) begin
                if (!stop && r_ent[k*8 +: 8] != fde_pkg::CH_SPACE) begin
                    c_sname[len] = r_ent[k*8 +: 8];
                    len = len + 4'd1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        c_slen = len;
        for (int i = 0; i < fde_pkg::SNAME_BYTES; i++) begin
            if (!zf && 4'(i) < len && c_sname[i] == 8'h00) begin
                c_slen = 4'(i);
                zf     = 1'b1;
            end
        end
    end

    assign w_ln  = (r_idx == 8'd0) ? {4'd0, c_slen} : r_idx;
    assign w_a0  = (r_idx == 8'd0) ? c_sname[0] : r_c0;
    assign w_a1  = (r_idx == 8'd0) ? c_sname[1] : r_c1;
    assign w_dot = ((w_ln == 8'd1) && (w_a0 == fde_pkg::CH_DOT)) ||
                   ((w_ln == 8'd2) && (w_a0 == fde_pkg::CH_DOT) && (w_a1 == fde_pkg::CH_DOT));
    assign w_fit = ({1'b0, r_off} + {13'd0, w_ln} + 21'd1) < {1'b0, r_limit};

    // long-name character write
    assign w_off = fde_pkg::lfn_off(r_k);
    assign w_ch  = {r_ent[{w_off + 5'd1, 3'b000} +: 8], r_ent[{w_off, 3'b000} +: 8]};
    assign w_wa  = r_base + {5'd0, r_k};
    always_comb begin
        if (r_k == 4'd13) begin
            w_wd = 8'h00;
            w_we = (r_state == S_LFN) && ((r_ent[7:0] & fde_pkg::ORDER_LAST) != 8'h00)
                   && !w_wa[8];
        end else begin
            w_wd = (w_ch == 16'h0000 || w_ch == 16'hFFFF) ? 8'h00 : w_ch[7:0];
            w_we = (r_state == S_LFN) && !w_wa[8];
        end
    end

    assign w_char  = (r_pos == r_len) ? fde_pkg::CH_NEWLINE :
                     (r_long ? w_rdval : c_sname[r_pos[3:0]]);
    assign w_n     = {1'b0, r_cnt} + 4'd1;
    always_comb begin
        n_chunk = r_chunk;
        n_chunk[{r_cnt, 3'b000} +: 8] = w_char;
    end

    assign o_pop = (r_state == S_IDLE) && !i_qctl.empty;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa[7:0]] <= w_wd;
        r_rd  <= r_mem[w_rd_addr];
        r_rdv <= r_vld[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= fde_pkg::LIMIT_RESET;
            r_off       <= 20'd0;
            r_done      <= 1'b0;
            r_vld       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_out_limit_we) r_limit <= i_out_limit;
            if (w_we) r_vld[w_wa[7:0]] <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.clr) begin
                            r_off <= 20'd0;
                            if (i_cmd.op != fde_pkg::OP_CLR) r_vld  <= '0;
                            if (i_cmd.op != fde_pkg::OP_END) r_done <= 1'b0;
                        end
                        r_ent <= i_cmd.ent;
                        if (i_cmd.clr || !r_done) begin
                            unique case (i_cmd.op)
                                fde_pkg::OP_END: begin
                                    r_done          <= 1'b1;
                                    o_text_chunk    <= 64'd0;
                                    o_chunk_bytes   <= 4'd0;
                                    o_kind          <= fde_pkg::KIND_END;
                                    o_last          <= 1'b1;
                                    o_written_count <= i_cmd.clr ? 20'd0 : r_off;
                                    o_out_valid     <= 1'b1;
                                    r_state         <= S_OUT;
                                end
                                fde_pkg::OP_CLR: r_vld <= '0;
                                fde_pkg::OP_LFN: begin
                                    if (w_slot != 6'd0 && w_slot <= 6'(fde_pkg::MAX_SLOTS)) begin
                                        r_base  <= 9'(({3'd0, w_slot} - 9'd1) * 9'd13);
                                        r_k     <= 4'd0;
                                        r_state <= S_LFN;
                                    end
                                end
                                fde_pkg::OP_NAME: begin
                                    r_idx   <= 8'd0;
                                    r_state <= S_SRD;
                                end
                                default: r_state <= S_IDLE;
                            endcase
                        end
                    end
                end
                S_LFN: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd13) r_state <= S_IDLE;
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (r_idx == 8'd0) r_c0 <= w_rdval;
                    if (r_idx == 8'd1) r_c1 <= w_rdval;
                    if (w_rdval == 8'h00 || r_idx == 8'd255) begin
                        r_state <= S_DEC;
                    end else begin
                        r_idx   <= r_idx + 8'd1;
                        r_state <= S_SRD;
                    end
                end
                S_DEC: begin
                    if (w_dot) begin
                        r_vld   <= '0;
                        r_state <= S_IDLE;
                    end else if (!w_fit) begin
                        r_vld           <= '0;
                        r_done          <= 1'b1;
                        o_text_chunk    <= 64'd0;
                        o_chunk_bytes   <= 4'd0;
                        o_kind          <= fde_pkg::KIND_LIMIT;
                        o_last          <= 1'b1;
                        o_written_count <= r_off;
                        o_out_valid     <= 1'b1;
                        r_state         <= S_OUT;
                    end else begin
                        r_len   <= w_ln;
                        r_long  <= (r_idx != 8'd0);
                        r_pos   <= 8'd0;
                        r_cnt   <= 3'd0;
                        r_chunk <= 64'd0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: r_state <= S_EACC;
                S_EACC: begin
                    r_pos <= r_pos + 8'd1;
                    if (r_cnt == 3'd7 || r_pos == r_len) begin
                        o_text_chunk    <= n_chunk;
                        o_chunk_bytes   <= w_n;
                        o_kind          <= fde_pkg::KIND_TEXT;
                        o_last          <= (r_pos == r_len);
                        o_written_count <= r_off + {16'd0, w_n};
                        r_off           <= r_off + {16'd0, w_n};
                        o_out_valid     <= 1'b1;
                        r_chunk         <= 64'd0;
                        r_cnt           <= 3'd0;
                        r_state         <= S_OUT;
                    end else begin
                        r_chunk <= n_chunk;
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_ERD;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        if (o_kind == fde_pkg::KIND_TEXT && !o_last) begin
                            r_state <= S_ERD;
                        end else begin
                            if (o_kind == fde_pkg::KIND_TEXT) r_vld <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_OUT))
        else $error("result shown outside output state");

    a_text_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == fde_pkg::KIND_TEXT) |-> (o_chunk_bytes != 4'd0))
        else $error("empty text chunk");

    a_store_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_kind == fde_pkg::KIND_TEXT && o_last)
        |=> (r_vld == '0))
        else $error("name store not cleared after name");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_qctl.empty && (r_state == S_IDLE))
        else $error("queue popped while busy");

endmodule

// ===== src/fat_directory_name_extractor_top.sv =====
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// input     | i_in_valid / o_in_ready    | i_dir_byte, i_new_listing
// output    | o_out_valid / i_out_ready  | o_text_chunk, o_chunk_bytes, o_kind, o_last,
//           |                            | o_written_count
// config    | i_out_limit_we             | i_out_limit
//
// a request byte can be taken every cycle; the 32nd byte of an entry stalls only when the
// two-deep entry queue is full
// the back end handles one entry at a time: a long-name entry writes its chars into the
// name store; a name reads its stored chars one by one to find its length, then reads
// each emitted char and hands out chunks, through the single read port of the name store
// reset (synchronous, active low) clears control state and the name store valid bits;
// a waiting result holds the back end until taken
module fat_directory_name_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_limit_we,
    input  logic [19:0] i_out_limit,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_dir_byte,
    input  logic        i_new_listing,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_text_chunk,
    output logic [3:0]  o_chunk_bytes,
    output logic [1:0]  o_kind,
    output logic        o_last,
    output logic [19:0] o_written_count
);

    fde_pkg::t_cmd  w_push_cmd;
    fde_pkg::t_cmd  w_head_cmd;
    fde_pkg::t_qctl w_qctl;
    logic           w_push;
    logic           w_pop;

    // front: gathers bytes into entries and classifies them
    fde_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_dir_byte    (i_dir_byte),
        .i_new_listing (i_new_listing),
        .i_q_full      (w_qctl.full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // entry queue decouples the byte stream from name output
    fde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_ctl   (w_qctl)
    );

    // back: long-name store, name assembly and chunked output
    fde_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_out_limit_we  (i_out_limit_we),
        .i_out_limit     (i_out_limit),
        .i_cmd           (w_head_cmd),
        .i_qctl          (w_qctl),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_text_chunk    (o_text_chunk),
        .o_chunk_bytes   (o_chunk_bytes),
        .o_kind          (o_kind),
        .o_last          (o_last),
        .o_written_count (o_written_count)
    );

endmodule
